/* rtl/cartesian_to_spherical_macros.svh */
// Assertion macros shared by the cartesian_to_spherical RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH
`ifndef ASSERT_OFF
`define C2S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define C2S_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C2S_ASSERT(lbl, prop, msg)
`define C2S_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

/* rtl/c2s_pkg.sv */
// Types, constants and the CORDIC angle table for cartesian_to_spherical.
// Used by c2s_cordic and the top level; depends on nothing.
package c2s_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int TABLE_LEN    = 40;
  localparam int CORDIC_N     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CORDIC_LAT   = CORDIC_N + 2;

  localparam int DW      = 33;
  localparam int CW      = 37;
  localparam int AW      = 32;
  localparam int SQ_BITS = 34;
  localparam int SQW     = 68;

  localparam logic signed [AW-1:0] PI_Q      = 32'sd843314857;
  localparam logic signed [AW-1:0] HALF_PI_Q = 32'sd421657428;
  localparam logic signed [AW-1:0] TWO_PI_Q  = 32'sd1686629713;

  localparam logic signed [AW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
    32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2, 32'sd1, 32'sd0, 32'sd0, 32'sd0,
    32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0
  };

  typedef enum logic [1:0] {
    REG_ORIGIN_X     = 2'd0,
    REG_ORIGIN_Y     = 2'd1,
    REG_ORIGIN_Z     = 2'd2,
    REG_PHI_POSITIVE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } c2s_in_t;

  typedef struct packed {
    logic [32:0]        radius;
    logic [29:0]        polar_angle;
    logic signed [31:0] azimuth;
  } c2s_out_t;

endpackage

/* rtl/c2s_cordic.sv */
// Pipelined CORDIC vectoring unit computing atan2(y, x) in Q3.28 radians.
// Depends on c2s_pkg for widths, the step count and the angle table.
module c2s_cordic (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic signed [c2s_pkg::CW-1:0] in_y,
  input  logic signed [c2s_pkg::CW-1:0] in_x,
  output logic                        out_vld,
  output logic signed [c2s_pkg::AW-1:0] out_ang
);
  import c2s_pkg::*;

  logic                 vld_r [0:CORDIC_N];
  logic                 sp_r  [0:CORDIC_N];
  logic signed [CW-1:0] x_r   [0:CORDIC_N];
  logic signed [CW-1:0] y_r   [0:CORDIC_N];
  logic signed [AW-1:0] z_r   [0:CORDIC_N];

  logic                 sp_nxt;
  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [AW-1:0] z_nxt;
  logic                 out_vld_r;
  logic signed [AW-1:0] out_ang_r, ang_nxt;

  always_comb begin
    sp_nxt = (in_y == '0);
    x_nxt  = in_x;
    y_nxt  = in_y;
    z_nxt  = '0;
    if (sp_nxt) begin
      z_nxt = (in_x < 0) ? PI_Q : '0;
    end else if (in_x < 0) begin
      if (in_y >= 0) begin
        x_nxt = in_y;
        y_nxt = -in_x;
        z_nxt = HALF_PI_Q;
      end else begin
        x_nxt = -in_y;
        y_nxt = in_x;
        z_nxt = -HALF_PI_Q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sp_r[0] <= sp_nxt;
    x_r[0]  <= x_nxt;
    y_r[0]  <= y_nxt;
    z_r[0]  <= z_nxt;
  end

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = x_r[k] >>> k;
    assign ys = y_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sp_r[k+1] <= sp_r[k];
      if (sp_r[k]) begin
        x_r[k+1] <= x_r[k];
        y_r[k+1] <= y_r[k];
        z_r[k+1] <= z_r[k];
      end else if (y_r[k] >= 0) begin
        x_r[k+1] <= x_r[k] + ys;
        y_r[k+1] <= y_r[k] - xs;
        z_r[k+1] <= z_r[k] + ATAN_TAB[k];
      end else begin
        x_r[k+1] <= x_r[k] - ys;
        y_r[k+1] <= y_r[k] + xs;
        z_r[k+1] <= z_r[k] - ATAN_TAB[k];
      end
    end
  end

  always_comb begin
    ang_nxt = z_r[CORDIC_N];
    if (z_r[CORDIC_N] > PI_Q) begin
      ang_nxt = PI_Q;
    end else if (z_r[CORDIC_N] < -PI_Q) begin
      ang_nxt = -PI_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    out_ang_r <= ang_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_ang = out_ang_r;

endmodule

/* rtl/cartesian_to_spherical.sv */
// Top level of the Cartesian to spherical converter.
// Depends on c2s_pkg, c2s_cordic and cartesian_to_spherical_macros.svh.
//
// Usage:
// A point is taken on in_data at each rising edge where start is high and
// busy is low. busy is always low, so one transaction can enter every cycle.
// Each point gives one result on out_data, marked by out_valid for exactly
// one cycle. Throughput is one point per cycle; each point passes through
// the 34 stages of the square root pipeline and then the 32 stages of the
// CORDIC units that run after it.
// The origin and the azimuth mode are written through cfg_we, cfg_index and
// cfg_wdata while no transaction is in flight.
// Reset clears the configuration registers and all valid bits; points in
// flight are dropped. The receiver cannot stall, so the pipeline never holds.
module cartesian_to_spherical (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  c2s_pkg::c2s_in_t  in_data,
  output logic              out_valid,
  output c2s_pkg::c2s_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import c2s_pkg::*;
  `include "cartesian_to_spherical_macros.svh"

  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic               phi_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r   <= '0;
      org_y_r   <= '0;
      org_z_r   <= '0;
      phi_pos_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:     org_x_r   <= cfg_wdata;
        REG_ORIGIN_Y:     org_y_r   <= cfg_wdata;
        REG_ORIGIN_Z:     org_z_r   <= cfg_wdata;
        REG_PHI_POSITIVE: phi_pos_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                 d_vld_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= {in_data.pos_x[31], in_data.pos_x} - {org_x_r[31], org_x_r};
    dy_r <= {in_data.pos_y[31], in_data.pos_y} - {org_y_r[31], org_y_r};
    dz_r <= {in_data.pos_z[31], in_data.pos_z} - {org_z_r[31], org_z_r};
  end

  logic [DW-1:0] mx, my, mz;
  assign mx = dx_r[DW-1] ? (DW'(0) - dx_r) : dx_r;
  assign my = dy_r[DW-1] ? (DW'(0) - dy_r) : dy_r;
  assign mz = dz_r[DW-1] ? (DW'(0) - dz_r) : dz_r;

  logic                 sq_vld_r;
  logic [65:0]          sqx_r, sqy_r, sqz_r;
  logic signed [DW-1:0] sdx_r, sdy_r, sdz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r <= 66'(mx) * 66'(mx);
    sqy_r <= 66'(my) * 66'(my);
    sqz_r <= 66'(mz) * 66'(mz);
    sdx_r <= dx_r;
    sdy_r <= dy_r;
    sdz_r <= dz_r;
  end

  logic [65:0] sxy;
  assign sxy = sqx_r + sqy_r;

  logic                 rt_vld_r [0:SQ_BITS];
  logic [SQW-1:0]       rem_r    [0:1][0:SQ_BITS];
  logic [SQ_BITS-1:0]   root_r   [0:1][0:SQ_BITS];
  logic signed [DW-1:0] qx_r     [0:SQ_BITS];
  logic signed [DW-1:0] qy_r     [0:SQ_BITS];
  logic signed [DW-1:0] qz_r     [0:SQ_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_vld_r[0] <= 1'b0;
    end else begin
      rt_vld_r[0] <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0][0]  <= SQW'(sxy);
    rem_r[1][0]  <= SQW'(sxy + sqz_r);
    root_r[0][0] <= '0;
    root_r[1][0] <= '0;
    qx_r[0]      <= sdx_r;
    qy_r[0]      <= sdy_r;
    qz_r[0]      <= sdz_r;
  end

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
    localparam int B = SQ_BITS - 1 - k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[k+1] <= 1'b0;
      end else begin
        rt_vld_r[k+1] <= rt_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      qx_r[k+1] <= qx_r[k];
      qy_r[k+1] <= qy_r[k];
      qz_r[k+1] <= qz_r[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SQW-1:0] trial;
      assign trial = (SQW'(root_r[l][k]) << (B + 1)) + (SQW'(1) << (2 * B));

      always_ff @(posedge clk) begin
        if (rem_r[l][k] >= trial) begin
          rem_r[l][k+1]  <= rem_r[l][k] - trial;
          root_r[l][k+1] <= root_r[l][k] | (SQ_BITS'(1) << B);
        end else begin
          rem_r[l][k+1]  <= rem_r[l][k];
          root_r[l][k+1] <= root_r[l][k];
        end
      end
    end
  end

  logic                 th_vld, ph_vld;
  logic signed [AW-1:0] th_ang, ph_ang;

  c2s_cordic u_theta (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rt_vld_r[SQ_BITS]),
    .in_y    (CW'(signed'({1'b0, root_r[0][SQ_BITS]}))),
    .in_x    (CW'(qz_r[SQ_BITS])),
    .out_vld (th_vld),
    .out_ang (th_ang)
  );

  c2s_cordic u_phi (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rt_vld_r[SQ_BITS]),
    .in_y    (CW'(qy_r[SQ_BITS])),
    .in_x    (CW'(qx_r[SQ_BITS])),
    .out_vld (ph_vld),
    .out_ang (ph_ang)
  );

  logic [32:0] rad_r  [0:CORDIC_LAT];
  logic        zero_r [0:CORDIC_LAT];

  always_ff @(posedge clk) begin
    rad_r[0]  <= root_r[1][SQ_BITS][32:0];
    zero_r[0] <= (root_r[1][SQ_BITS] == '0);
  end

  for (genvar k = 0; k < CORDIC_LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      rad_r[k+1]  <= rad_r[k];
      zero_r[k+1] <= zero_r[k];
    end
  end

  logic                 out_valid_r;
  c2s_out_t             out_data_r;
  logic signed [AW-1:0] theta_nxt, phi_nxt;

  always_comb begin
    theta_nxt = th_ang;
    phi_nxt   = ph_ang;
    if (th_ang < 0) begin
      theta_nxt = '0;
    end
    if (phi_pos_r && ph_ang < 0) begin
      phi_nxt = ph_ang + TWO_PI_Q;
    end
    if (zero_r[CORDIC_LAT-1]) begin
      theta_nxt = '0;
      phi_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= th_vld && ph_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.radius      <= rad_r[CORDIC_LAT-1];
    out_data_r.polar_angle <= theta_nxt[29:0];
    out_data_r.azimuth     <= phi_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `C2S_ASSERT(a_theta_range, out_valid |-> out_data.polar_angle <= PI_Q[29:0], "theta above pi")
  `C2S_ASSERT(a_zero_radius, (out_valid && out_data.radius == '0) |-> (out_data.polar_angle == '0 && out_data.azimuth == '0), "angles not zero at origin")
  `C2S_ASSERT(a_phi_range, (out_valid && !phi_pos_r) |-> (out_data.azimuth <= PI_Q && out_data.azimuth >= -PI_Q), "azimuth out of range")
  `C2S_ASSERT(a_lanes_aligned, th_vld == ph_vld, "CORDIC lanes out of step")
  `C2S_ASSERT_ANY(a_reset_quiet, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

/* dv/tb_cartesian_to_spherical.sv */
// Self-checking testbench for cartesian_to_spherical: random and directed points,
// predicted with a bit-exact integer model of the square roots and CORDIC passes.
// Depends on c2s_pkg and the cartesian_to_spherical RTL.
`timescale 1ns / 100ps

module tb_cartesian_to_spherical;
  import c2s_pkg::*;

  localparam longint PI_L = 843314857;
  localparam longint TWO_PI_L = 1686629713;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  c2s_in_t in_data;
  logic out_valid;
  c2s_out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;

  longint org_x, org_y, org_z;
  bit phi_pos;

  c2s_in_t point_q[$];
  c2s_out_t sph_expected_q[$];
  int gap_left;
  int cycle_count;
  int fail_count;

  cartesian_to_spherical dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [33:0] int_sqrt(logic [67:0] v);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (y == 0) return (x >= 0) ? 0 : PI_L;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = PI_L / 2;
      end else begin
        t = x; x = -y; y = t; z = -(PI_L / 2);
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z -= longint'(ATAN_TAB[i]);
      end
    end
    if (z > PI_L) z = PI_L;
    if (z < -PI_L) z = -PI_L;
    return z;
  endfunction

  function automatic c2s_out_t to_spherical(c2s_in_t p);
    longint dx, dy, dz, theta, phi;
    logic [63:0] sqx, sqy, sqz;
    logic [67:0] sq_xy, sq_all;
    logic [33:0] rho, r;
    c2s_out_t o;
    dx = longint'(p.pos_x) - org_x;
    dy = longint'(p.pos_y) - org_y;
    dz = longint'(p.pos_z) - org_z;
    sqx = dx * dx;
    sqy = dy * dy;
    sqz = dz * dz;
    sq_xy = 68'(sqx) + 68'(sqy);
    sq_all = sq_xy + 68'(sqz);
    rho = int_sqrt(sq_xy);
    r = int_sqrt(sq_all);
    theta = 0;
    phi = 0;
    if (r != 0) begin
      theta = vector_angle(longint'(rho), dz);
      phi = vector_angle(dy, dx);
      if (theta < 0) theta = 0;
      if (phi_pos && phi < 0) phi += TWO_PI_L;
    end
    o.radius = r[32:0];
    o.polar_angle = theta[29:0];
    o.azimuth = phi[31:0];
    return o;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    c2s_in_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    point_q.insert(point_q.size(), p);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X: org_x = longint'($signed(val));
      REG_ORIGIN_Y: org_y = longint'($signed(val));
      REG_ORIGIN_Z: org_z = longint'($signed(val));
      REG_PHI_POSITIVE: phi_pos = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (point_q.size() != 0 || start || sph_expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Predicted at acceptance, so the configuration is the one in force.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) sph_expected_q.insert(sph_expected_q.size(), to_spherical(in_data));
      if (start && busy) begin
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (point_q.size() != 0) begin
        start <= 1'b1;
        in_data <= point_q.pop_front();
        gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    c2s_out_t e;
    if (rst_n && out_valid) begin
      if (sph_expected_q.size() == 0) begin
        $error("unexpected transaction: %h", out_data);
        fail_count++;
      end else begin
        e = sph_expected_q.pop_front();
        if (out_data.radius !== e.radius) begin
          $error("radius expected %0d actual %0d", e.radius, out_data.radius);
          fail_count++;
        end
        if (out_data.polar_angle !== e.polar_angle) begin
          $error("polar_angle expected %0d actual %0d", e.polar_angle, out_data.polar_angle);
          fail_count++;
        end
        if (out_data.azimuth !== e.azimuth) begin
          $error("azimuth expected %0d actual %0d", e.azimuth, out_data.azimuth);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    fail_count = 0;
    org_x = 0; org_y = 0; org_z = 0; phi_pos = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_point(0, 0, 0);
    add_point(32'h10000, 0, 0);
    add_point(32'hffff_0000, 0, 0);
    add_point(0, 32'h10000, 0);
    add_point(0, 32'hffff_0000, 0);
    add_point(0, 0, 32'h10000);
    add_point(0, 0, 32'hffff_0000);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_point(32'hffff_ffff, 32'hffff_ffff, 1);
    add_point(32'hffff_ffff, 1, 32'hffff_ffff);
    drain();

    write_reg(REG_PHI_POSITIVE, 32'd1);
    write_reg(REG_ORIGIN_X, 32'h7fff_ffff);
    write_reg(REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(REG_ORIGIN_Z, 32'h7fff_ffff);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h0, 32'h8000_0000, 32'h7fff_ffff);
    add_point(32'h7fff_0000, 32'h8000_ffff, 32'h7fff_ffff);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_ORIGIN_X, (ph == 4) ? 32'h8000_0000 : rand_coord());
      write_reg(REG_ORIGIN_Y, (ph == 4) ? 32'h7fff_ffff : rand_coord());
      write_reg(REG_ORIGIN_Z, (ph == 0) ? 32'h0 : rand_coord());
      write_reg(REG_PHI_POSITIVE, ph % 2);
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(0, 19) == 0)
          add_point(32'(org_x), 32'(org_y), 32'(org_z));
        else if ($urandom_range(0, 9) == 0)
          add_point(32'(org_x), rand_coord(), rand_coord());
        else if ($urandom_range(0, 9) == 0)
          add_point(rand_coord(), 32'(org_y), rand_coord());
        else
          add_point(rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
